>>> rtl/opnp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// opnp_pkg
// Types and constants shared by the opcode pattern NOP patcher modules.
// ----------------------------------------------------------------------------
package opnp_pkg;

    localparam logic [7:0] ByteEsc = 8'h0F;
    localparam logic [7:0] ByteGrp = 8'h01;
    localparam logic [7:0] ByteSet = 8'hCB;
    localparam logic [7:0] ByteClr = 8'hCA;
    localparam logic [7:0] ByteNop = 8'h90;

    localparam int          CntW       = 32;
    localparam logic [CntW-1:0] CntMax = '1;

    // APB: one 32-bit register at byte address 0
    localparam int ApbAddrW = 3;
    localparam int ApbDataW = 32;
    localparam logic REG_PATCH_ENABLE = 1'b0;   // register index, paddr[2]

    localparam int QueueDepthDef = 2;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       region_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0]      out_byte;
        logic            out_last;
        logic [CntW-1:0] set_count;
        logic [CntW-1:0] clear_count;
    } t_out_item;

    // One classified input item: up to three bytes to emit, all with the same counts
    typedef struct packed {
        logic [1:0]      beat_cnt;
        logic [2:0][7:0] bytes;
        logic            last;
        logic [CntW-1:0] set_count;
        logic [CntW-1:0] clear_count;
    } t_entry;

endpackage : opnp_pkg
`default_nettype wire

>>> rtl/opnp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// opnp_front
// Accepts code bytes, keeps the two-byte window and the counters, detects the
// 0F 01 CB / 0F 01 CA patterns and pushes one entry per item that emits bytes.
// ----------------------------------------------------------------------------
module opnp_front
    import opnp_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_patch_enable,
    input  wire logic     i_valid,
    input  wire t_in_item i_in_data,
    input  wire logic     i_full,
    output logic          o_push,
    output t_entry        o_entry
);

    logic [7:0]      r_win0, r_win1, n_win0, n_win1;
    logic [1:0]      r_fill, n_fill;
    logic [CntW-1:0] r_set, r_clr, n_set, n_clr;

    logic       accept;
    logic       match;
    logic [7:0] b;
    logic       last_in;
    t_entry     entry;

    assign accept  = i_valid && !i_full;
    assign b       = i_in_data.code_byte;
    assign last_in = i_in_data.region_end;

    assign match = i_patch_enable && (r_fill == 2'd2) && (r_win0 == ByteEsc) &&
                   (r_win1 == ByteGrp) && ((b == ByteSet) || (b == ByteClr));

    always_comb begin
        n_win0 = r_win0;
        n_win1 = r_win1;
        n_fill = r_fill;
        n_set  = r_set;
        n_clr  = r_clr;
        entry  = '0;
        if (match) begin
            if (b == ByteSet) begin
                if (r_set != CntMax) n_set = r_set + 1'b1;
            end else begin
                if (r_clr != CntMax) n_clr = r_clr + 1'b1;
            end
            n_fill         = 2'd0;
            entry.beat_cnt = 2'd3;
            entry.bytes    = {ByteNop, ByteNop, ByteNop};
            entry.last     = last_in;
        end else if (r_fill == 2'd2) begin
            // shift out the oldest byte; on region end flush the rest as well
            entry.bytes[0] = r_win0;
            entry.bytes[1] = r_win1;
            entry.bytes[2] = b;
            entry.beat_cnt = last_in ? 2'd3 : 2'd1;
            entry.last     = last_in;
            n_win0         = r_win1;
            n_win1         = b;
        end else if (r_fill == 2'd1) begin
            entry.bytes[0] = r_win0;
            entry.bytes[1] = b;
            entry.beat_cnt = last_in ? 2'd2 : 2'd0;
            entry.last     = last_in;
            n_win1         = b;
            n_fill         = 2'd2;
        end else begin
            entry.bytes[0] = b;
            entry.beat_cnt = last_in ? 2'd1 : 2'd0;
            entry.last     = last_in;
            n_win0         = b;
            n_fill         = 2'd1;
        end
        entry.set_count   = n_set;
        entry.clear_count = n_clr;
        if (last_in) begin
            n_fill = 2'd0;
            n_set  = '0;
            n_clr  = '0;
        end
    end

    assign o_push  = accept && (entry.beat_cnt != 2'd0);
    assign o_entry = entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= 2'd0;
            r_set  <= '0;
            r_clr  <= '0;
        end else if (accept) begin
            r_fill <= n_fill;
            r_set  <= n_set;
            r_clr  <= n_clr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_win0 <= n_win0;
            r_win1 <= n_win1;
        end
    end

endmodule : opnp_front
`default_nettype wire

>>> rtl/opnp_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// opnp_queue
// Small FIFO of classified entries between the front and the back.
// ----------------------------------------------------------------------------
module opnp_queue
    import opnp_pkg::*;
#(
    parameter int Depth = QueueDepthDef
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_entry i_entry,
    input  wire logic   i_pop,
    output logic        o_full,
    output logic        o_valid,
    output t_entry      o_entry
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntQW = $clog2(Depth + 1);

    t_entry             r_mem [Depth];
    logic [PtrW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CntQW-1:0]   r_cnt;
    logic               do_push, do_pop;

    assign o_full  = (r_cnt == CntQW'(Depth));
    assign o_valid = (r_cnt != '0);
    assign o_entry = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(Depth - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(Depth - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule : opnp_queue
`default_nettype wire

>>> rtl/opnp_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// opnp_back
// Splits each queued entry into output beats, one per cycle unless the held
// output beat is stalled, into the output register.
// ----------------------------------------------------------------------------
module opnp_back
    import opnp_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_valid,
    input  wire t_entry i_entry,
    output logic        o_pop,
    output logic        o_valid,
    input  wire logic   i_stall,
    output t_out_item   o_out_data
);

    logic [1:0] r_idx;
    logic       r_out_valid;
    t_out_item  r_out;
    logic       load;
    logic       final_beat;

    assign load       = i_valid && (!r_out_valid || !i_stall);
    assign final_beat = (r_idx == (i_entry.beat_cnt - 2'd1));
    assign o_pop      = load && final_beat;
    assign o_valid    = r_out_valid;
    assign o_out_data = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_idx       <= final_beat ? 2'd0 : r_idx + 2'd1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out.out_byte    <= i_entry.bytes[r_idx];
            r_out.out_last    <= i_entry.last && final_beat;
            r_out.set_count   <= i_entry.set_count;
            r_out.clear_count <= i_entry.clear_count;
        end
    end

endmodule : opnp_back
`default_nettype wire

>>> rtl/opcode_pattern_nop_patcher.sv
`default_nettype none
// ----------------------------------------------------------------------------
// opcode_pattern_nop_patcher
// Copies a code byte stream, replacing 0F 01 CB / 0F 01 CA with 90 90 90.
// ----------------------------------------------------------------------------
// Takes one code byte per cycle while o_stall is low and gives one output beat
// per cycle while i_stall is low. A byte is held in a two-byte window before it
// goes out, so output trails input by two bytes; a matched pattern or a region
// end emits up to three beats for one input byte, which go out one at a time.
// A QueueDepth-entry queue between the classifier and the beat serializer
// absorbs such bursts; input stalls only once that queue is full. With
// patch_enable = 0 bytes pass through unchanged. Counts on each beat are the
// region's totals so far and restart at zero after a beat marked out_last.
// ----------------------------------------------------------------------------
module opcode_pattern_nop_patcher
    import opnp_pkg::*;
#(
    parameter int QueueDepth = QueueDepthDef
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire t_in_item            i_in_data,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output t_out_item                o_out_data,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [ApbAddrW-1:0] paddr,
    input  wire logic [ApbDataW-1:0] pwdata,
    output logic      [ApbDataW-1:0] prdata,
    output logic                     pready
);

    logic   r_patch_enable;
    logic   cfg_hit;
    logic   q_full, q_valid, q_push, q_pop;
    t_entry push_entry, head_entry;

    assign pready  = 1'b1;
    assign cfg_hit = (paddr[2] == REG_PATCH_ENABLE) && (paddr[1:0] == 2'b00);
    assign prdata  = cfg_hit ? {{(ApbDataW-1){1'b0}}, r_patch_enable} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_patch_enable <= 1'b0;
        end else if (psel && penable && pwrite && pready && cfg_hit) begin
            r_patch_enable <= pwdata[0];
        end
    end

    assign o_stall = q_full;

    opnp_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_patch_enable (r_patch_enable),
        .i_valid        (i_valid),
        .i_in_data      (i_in_data),
        .i_full         (q_full),
        .o_push         (q_push),
        .o_entry        (push_entry)
    );

    opnp_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (push_entry),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_entry (head_entry)
    );

    opnp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (q_valid),
        .i_entry    (head_entry),
        .o_pop      (q_pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_data (o_out_data)
    );

endmodule : opcode_pattern_nop_patcher
`default_nettype wire

>>> rtl/opnp_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// opnp_checker
// Port-level checks on the output channel of the NOP patcher.
// ----------------------------------------------------------------------------
module opnp_checker
    import opnp_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_item i_out_data
);

    logic            out_accept;
    logic            r_prev_last;
    logic [CntW-1:0] r_prev_set, r_prev_clr;

    assign out_accept = i_out_valid && !i_out_stall;

    // track the previous accepted beat; region start acts like after a last beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_last <= 1'b1;
            r_prev_set  <= '0;
            r_prev_clr  <= '0;
        end else if (out_accept) begin
            r_prev_last <= i_out_data.out_last;
            r_prev_set  <= i_out_data.set_count;
            r_prev_clr  <= i_out_data.clear_count;
        end
    end

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid)
        else $error("output valid dropped while stalled");

    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> $stable(i_out_data))
        else $error("output beat changed while stalled");

    a_count_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_accept && !r_prev_last |->
            (i_out_data.set_count >= r_prev_set) &&
            (i_out_data.clear_count >= r_prev_clr))
        else $error("pattern count decreased inside a region");

    a_count_nop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_accept && !r_prev_last &&
            ((i_out_data.set_count != r_prev_set) ||
             (i_out_data.clear_count != r_prev_clr)) |->
            (i_out_data.out_byte == ByteNop))
        else $error("count advanced on a beat that is not a NOP");

endmodule : opnp_checker

bind opcode_pattern_nop_patcher opnp_checker u_opnp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_valid),
    .i_out_stall (i_stall),
    .i_out_data  (o_out_data)
);
`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the opcode pattern NOP patcher.
// ----------------------------------------------------------------------------
// Every accepted code byte goes through a local model of the patcher. The
// model keeps its own two-byte window, region counters and patch enable, and
// it queues the output beats that the byte should cause. Each beat that leaves
// the block is compared field by field with the oldest queued beat.
// A short scripted part covers reset, pass-through, both patterns, overlaps
// and region ends. A longer random part follows, made mostly of real and
// near-miss patterns, in phases with patching on and off. Both handshakes
// idle at random, except in one quiet phase.
// ----------------------------------------------------------------------------
module tb;
    import opnp_pkg::*;

    typedef t_out_item [2:0] t_beat_set;

    typedef struct {
        logic        is_cfg;
        logic        cfg_idx;
        logic [31:0] cfg_data;
        t_in_item    item;
        int          n_typed;     // -1: take the beats from the model
        t_beat_set   typed;
    } t_row;

    localparam logic REG_UNUSED = 1'b1;   // no register at this index
    localparam int   IDLE_PCT   = 32;
    localparam int   PHASE_LEN  = 87;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    t_in_item            i_in_data = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    t_out_item           o_out_data;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ApbAddrW-1:0] paddr = '0;
    logic [ApbDataW-1:0] pwdata = '0;
    logic [ApbDataW-1:0] prdata;
    logic                pready;

    opcode_pattern_nop_patcher dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_in_data  (i_in_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_data (o_out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // model state
    logic            patch_en;
    logic [7:0]      win_bytes [2];
    int              win_fill;
    logic [CntW-1:0] set_total;
    logic [CntW-1:0] clear_total;

    t_out_item expected_beats [$];
    t_row      script [$];
    int        err_count;
    int        items_sent;
    int        beats_checked;
    int        triples_patched;
    logic      no_idle;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        err_count++;
    endtask

    function automatic t_out_item mk_beat(input logic [7:0] b, input logic last,
                                          input logic [CntW-1:0] s,
                                          input logic [CntW-1:0] c);
        t_out_item r;
        r.out_byte    = b;
        r.out_last    = last;
        r.set_count   = s;
        r.clear_count = c;
        return r;
    endfunction

    function automatic int patch_step(input t_in_item it, output t_beat_set beats);
        int n;
        n     = 0;
        beats = '0;
        if (patch_en && win_fill == 2 && win_bytes[0] == ByteEsc &&
            win_bytes[1] == ByteGrp &&
            (it.code_byte == ByteSet || it.code_byte == ByteClr)) begin
            if (it.code_byte == ByteSet) begin
                if (set_total != CntMax) set_total++;
            end else if (clear_total != CntMax) begin
                clear_total++;
            end
            win_fill = 0;
            for (int k = 0; k < 3; k++)
                beats[k] = mk_beat(ByteNop, (k == 2) && it.region_end, set_total,
                                   clear_total);
            n = 3;
            triples_patched++;
        end else begin
            if (win_fill == 2) begin
                beats[n] = mk_beat(win_bytes[0], 1'b0, set_total, clear_total);
                n++;
                win_bytes[0] = win_bytes[1];
                win_bytes[1] = it.code_byte;
            end else begin
                win_bytes[win_fill] = it.code_byte;
                win_fill++;
            end
            if (it.region_end) begin
                for (int k = 0; k < win_fill; k++) begin
                    beats[n] = mk_beat(win_bytes[k], k + 1 == win_fill, set_total,
                                       clear_total);
                    n++;
                end
            end
        end
        // counts shown on this item's beats are the ones before the clear
        if (it.region_end) begin
            win_bytes[0] = '0;
            win_bytes[1] = '0;
            win_fill     = 0;
            set_total    = '0;
            clear_total  = '0;
        end
        return n;
    endfunction

    task automatic send_item(input t_in_item it, input int n_typed,
                             input t_beat_set typed);
        t_beat_set beats;
        int        n;
        @(negedge i_clk);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid   <= 1'b0;
            i_in_data <= t_in_item'($urandom);
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_data <= it;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        items_sent++;
        n = patch_step(it, beats);
        if (n_typed >= 0) begin
            n     = n_typed;
            beats = typed;
        end
        for (int k = 0; k < n; k++) expected_beats.push_back(beats[k]);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] data);
        @(negedge i_clk);
        i_valid <= 1'b0;
        // let the last beats drain and give the window stage time to settle
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (idx == REG_PATCH_ENABLE) patch_en = data[0];
        @(negedge i_clk);
        // read back the enable while the address still points at it
        if (idx == REG_PATCH_ENABLE && prdata !== {{(ApbDataW-1){1'b0}}, data[0]})
            report_mismatch($sformatf("prdata got %h want %h", prdata,
                                      {{(ApbDataW-1){1'b0}}, data[0]}));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic add_cfg(input logic idx, input logic [31:0] data);
        t_row r;
        r          = '{default: '0};
        r.is_cfg   = 1'b1;
        r.cfg_idx  = idx;
        r.cfg_data = data;
        script.push_back(r);
    endtask

    task automatic add_typed(input logic [7:0] b, input logic e, input int n,
                             input t_out_item b0, input t_out_item b1,
                             input t_out_item b2);
        t_row r;
        r          = '{default: '0};
        r.item     = '{code_byte: b, region_end: e};
        r.n_typed  = n;
        r.typed[0] = b0;
        r.typed[1] = b1;
        r.typed[2] = b2;
        script.push_back(r);
    endtask

    task automatic add_item(input logic [7:0] b, input logic e);
        add_typed(b, e, -1, '0, '0, '0);
    endtask

    // receiver side: stall at random outside the quiet phase
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= !no_idle && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            beats_checked++;
            if (expected_beats.size() == 0) begin
                report_mismatch($sformatf("unexpected beat %p", o_out_data));
            end else begin
                want = expected_beats.pop_front();
                if (o_out_data.out_byte !== want.out_byte)
                    report_mismatch($sformatf("out_byte got %h want %h",
                                              o_out_data.out_byte, want.out_byte));
                if (o_out_data.out_last !== want.out_last)
                    report_mismatch($sformatf("out_last got %b want %b",
                                              o_out_data.out_last, want.out_last));
                if (o_out_data.set_count !== want.set_count)
                    report_mismatch($sformatf("set_count got %0d want %0d",
                                              o_out_data.set_count, want.set_count));
                if (o_out_data.clear_count !== want.clear_count)
                    report_mismatch($sformatf("clear_count got %0d want %0d",
                                              o_out_data.clear_count,
                                              want.clear_count));
            end
        end
    end

    initial begin
        logic [7:0] burst [$];
        int         sent;
        int         wait_cycles;
        logic [31:0] phase_cfg [4];

        patch_en        = 1'b0;
        win_bytes[0]    = '0;
        win_bytes[1]    = '0;
        win_fill        = 0;
        set_total       = '0;
        clear_total     = '0;
        err_count       = 0;
        items_sent      = 0;
        beats_checked   = 0;
        triples_patched = 0;
        no_idle         = 1'b0;

        // patching off after reset: everything passes through
        add_typed(8'h00, 1'b0, 0, '0, '0, '0);
        add_typed(8'hFF, 1'b1, 2, mk_beat(8'h00, 1'b0, 0, 0),
                  mk_beat(8'hFF, 1'b1, 0, 0), '0);
        add_typed(ByteEsc, 1'b0, 0, '0, '0, '0);
        add_typed(ByteGrp, 1'b0, 0, '0, '0, '0);
        add_typed(ByteSet, 1'b1, 3, mk_beat(ByteEsc, 1'b0, 0, 0),
                  mk_beat(ByteGrp, 1'b0, 0, 0), mk_beat(ByteSet, 1'b1, 0, 0));
        add_typed(8'h55, 1'b1, 1, mk_beat(8'h55, 1'b1, 0, 0), '0, '0);
        // enable with all bits set, then a write to a missing register
        add_cfg(REG_PATCH_ENABLE, 32'hFFFF_FFFF);
        add_cfg(REG_UNUSED, 32'h0000_0000);
        add_typed(ByteEsc, 1'b0, 0, '0, '0, '0);
        add_typed(ByteGrp, 1'b0, 0, '0, '0, '0);
        add_typed(ByteSet, 1'b0, 3, mk_beat(ByteNop, 1'b0, 1, 0),
                  mk_beat(ByteNop, 1'b0, 1, 0), mk_beat(ByteNop, 1'b0, 1, 0));
        add_typed(ByteEsc, 1'b0, 0, '0, '0, '0);
        add_typed(ByteGrp, 1'b0, 0, '0, '0, '0);
        add_typed(ByteClr, 1'b1, 3, mk_beat(ByteNop, 1'b0, 1, 1),
                  mk_beat(ByteNop, 1'b0, 1, 1), mk_beat(ByteNop, 1'b1, 1, 1));
        // overlapping prefix, a byte right after a patch, match after a shift
        add_item(ByteEsc, 1'b0);
        add_item(ByteEsc, 1'b0);
        add_item(ByteGrp, 1'b0);
        add_item(ByteSet, 1'b0);
        add_item(ByteSet, 1'b0);
        add_item(ByteEsc, 1'b0);
        add_item(ByteGrp, 1'b0);
        add_item(ByteClr, 1'b0);
        add_item(8'h7F, 1'b0);
        add_item(ByteGrp, 1'b1);

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[i]) begin
            if (script[i].is_cfg)
                write_reg(script[i].cfg_idx, script[i].cfg_data);
            else
                send_item(script[i].item, script[i].n_typed, script[i].typed);
        end

        phase_cfg[0] = 32'h0000_0001;
        phase_cfg[1] = 32'hFFFF_FFFE;
        phase_cfg[2] = 32'h0000_0001;
        phase_cfg[3] = {31'($urandom), 1'($urandom_range(0, 1))};

        for (int p = 0; p < 4; p++) begin
            write_reg(REG_PATCH_ENABLE, phase_cfg[p]);
            no_idle = (p == 2);
            sent = 0;
            while (sent < PHASE_LEN) begin
                burst.delete();
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: begin
                        repeat ($urandom_range(0, 2)) burst.push_back(8'($urandom));
                        burst.push_back(ByteEsc);
                        burst.push_back(ByteGrp);
                        burst.push_back($urandom_range(0, 1) ? ByteSet : ByteClr);
                    end
                    5: begin
                        burst.push_back(ByteEsc);
                        burst.push_back(ByteGrp);
                        burst.push_back(8'($urandom));
                    end
                    6: begin
                        burst.push_back(ByteEsc);
                        burst.push_back(ByteEsc);
                        burst.push_back(ByteGrp);
                        burst.push_back($urandom_range(0, 1) ? ByteSet : ByteClr);
                    end
                    7: begin
                        burst.push_back(ByteEsc);
                        burst.push_back(8'($urandom));
                    end
                    default: begin
                        repeat ($urandom_range(1, 4)) burst.push_back(8'($urandom));
                    end
                endcase
                foreach (burst[k]) begin
                    send_item('{code_byte: burst[k],
                                region_end: ($urandom_range(0, 15) == 0)},
                              -1, '0);
                    sent++;
                end
            end
        end
        no_idle = 1'b0;
        // close the last region so the window flushes
        send_item('{code_byte: 8'($urandom), region_end: 1'b1}, -1, '0);

        @(negedge i_clk);
        i_valid <= 1'b0;
        wait_cycles = 0;
        while (expected_beats.size() != 0 && wait_cycles < 5000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (16) @(posedge i_clk);
        if (expected_beats.size() != 0)
            report_mismatch($sformatf("%0d beats never arrived", expected_beats.size()));

        $display("Sent %0d code bytes, checked %0d output beats.", items_sent,
                 beats_checked);
        $display("Model patched %0d triples across enable on/off phases.",
                 triples_patched);
        if (err_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
